[src/assert_macros.svh]
// assertion macros used by the checker file urb_checker.sv
// no dependencies; expects clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define URB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("urb assertion failed");

// next-cycle implication, disabled during reset
`define URB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("urb assertion failed");

`endif

[src/urb_pkg.sv]
// types and constants for the uart ring buffer unit
// used by the controller, the datapath and the top level
package urb_pkg;

  localparam int unsigned RX_DEPTH_DEF = 1024;
  localparam int unsigned TX_DEPTH_DEF = 32;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned ERR_W        = 3;

  // sticky error bit positions
  localparam int unsigned ERR_OVERRUN  = 0;
  localparam int unsigned ERR_FRAMING  = 1;
  localparam int unsigned ERR_OVERFLOW = 2;

  typedef enum logic [1:0] {
    REQ_LINE_BYTE = 2'd0,
    REQ_HOST_READ = 2'd1,
    REQ_HOST_WRITE = 2'd2,
    REQ_TX_READY  = 2'd3
  } urb_req_e_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } urb_state_t;

  typedef struct packed {
    urb_req_e_t        req_type;
    logic [BYTE_W-1:0] line_byte;
    logic              overrun_seen;
    logic              framing_error_seen;
    logic [BYTE_W-1:0] host_byte;
  } urb_req_t;

  typedef struct packed {
    logic              read_valid;
    logic [BYTE_W-1:0] read_byte;
    logic              send_valid;
    logic [BYTE_W-1:0] send_byte;
    logic              write_accepted;
    logic [ERR_W-1:0]  error_flags;
    logic              rx_nonempty;
    logic              tx_empty;
    logic              ready_irq_on;
  } urb_res_t;

  // controller to datapath commands
  typedef struct packed {
    logic exec;
    logic load;
  } urb_cmd_t;

endpackage

[src/urb_ifs.sv]
// valid/ready channel interfaces for request and result transactions
// no dependencies
interface urb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] line_byte;
  logic       overrun_seen;
  logic       framing_error_seen;
  logic [7:0] host_byte;

  modport source (output valid, req_type, line_byte, overrun_seen, framing_error_seen,
                  host_byte, input ready);
  modport sink (input valid, req_type, line_byte, overrun_seen, framing_error_seen,
                host_byte, output ready);
endinterface

interface urb_out_if;
  logic       valid;
  logic       ready;
  logic       read_valid;
  logic [7:0] read_byte;
  logic       send_valid;
  logic [7:0] send_byte;
  logic       write_accepted;
  logic [2:0] error_flags;
  logic       rx_nonempty;
  logic       tx_empty;
  logic       ready_irq_on;

  modport source (output valid, read_valid, read_byte, send_valid, send_byte,
                  write_accepted, error_flags, rx_nonempty, tx_empty, ready_irq_on,
                  input ready);
  modport sink (input valid, read_valid, read_byte, send_valid, send_byte,
                write_accepted, error_flags, rx_nonempty, tx_empty, ready_irq_on,
                output ready);
endinterface

[src/urb_ctrl.sv]
// controller fsm: sequences request execution and the result register
// depends on urb_pkg
module urb_ctrl
  import urb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output urb_cmd_t cmd
);

  urb_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.exec = in_valid;
      end
      ST_EXEC: begin
        cmd.load = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[src/urb_dp.sv]
// datapath: receive and transmit rings, sticky flags, result register
// depends on urb_pkg
module urb_dp
  import urb_pkg::*;
#(
  parameter int unsigned RX_DEPTH = RX_DEPTH_DEF,
  parameter int unsigned TX_DEPTH = TX_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  urb_cmd_t cmd,
  input  urb_req_t req,
  output urb_res_t res
);

  localparam int unsigned RX_PW = $clog2(RX_DEPTH);
  localparam int unsigned TX_PW = $clog2(TX_DEPTH);

  logic [BYTE_W-1:0] rx_mem [RX_DEPTH];
  logic [BYTE_W-1:0] tx_mem [TX_DEPTH];

  logic [RX_PW-1:0] rx_wptr_r, rx_wptr_nxt, rx_rptr_r, rx_rptr_nxt, rx_winc, rx_rinc;
  logic [TX_PW-1:0] tx_wptr_r, tx_wptr_nxt, tx_rptr_r, tx_rptr_nxt, tx_winc, tx_rinc;
  logic [ERR_W-1:0] err_r, err_nxt;
  logic             irq_r, irq_nxt;
  logic [BYTE_W-1:0] rx_rd_data_r, tx_rd_data_r;
  logic             pend_rd_r, pend_sd_r, pend_wr_r;
  urb_res_t         res_r;

  logic rx_full, rx_empty, tx_full, tx_empty;
  logic line_evt, rx_push, rx_pop, tx_push, tx_pop, tx_idle_evt;

  // wrap-around increments
  assign rx_winc = (rx_wptr_r == RX_PW'(RX_DEPTH - 1)) ? '0 : rx_wptr_r + RX_PW'(1);
  assign rx_rinc = (rx_rptr_r == RX_PW'(RX_DEPTH - 1)) ? '0 : rx_rptr_r + RX_PW'(1);
  assign tx_winc = (tx_wptr_r == TX_PW'(TX_DEPTH - 1)) ? '0 : tx_wptr_r + TX_PW'(1);
  assign tx_rinc = (tx_rptr_r == TX_PW'(TX_DEPTH - 1)) ? '0 : tx_rptr_r + TX_PW'(1);

  // one slot kept empty
  assign rx_full  = (rx_winc == rx_rptr_r);
  assign rx_empty = (rx_rptr_r == rx_wptr_r);
  assign tx_full  = (tx_winc == tx_rptr_r);
  assign tx_empty = (tx_rptr_r == tx_wptr_r);

  assign line_evt    = cmd.exec && (req.req_type == REQ_LINE_BYTE);
  assign rx_push     = line_evt && !rx_full;
  assign rx_pop      = cmd.exec && (req.req_type == REQ_HOST_READ) && !rx_empty;
  assign tx_push     = cmd.exec && (req.req_type == REQ_HOST_WRITE) && !tx_full;
  assign tx_pop      = cmd.exec && (req.req_type == REQ_TX_READY) && !tx_empty;
  assign tx_idle_evt = cmd.exec && (req.req_type == REQ_TX_READY) && tx_empty;

  always_comb begin
    rx_wptr_nxt = rx_push ? rx_winc : rx_wptr_r;
    rx_rptr_nxt = rx_pop ? rx_rinc : rx_rptr_r;
    tx_wptr_nxt = tx_push ? tx_winc : tx_wptr_r;
    tx_rptr_nxt = tx_pop ? tx_rinc : tx_rptr_r;
    err_nxt     = err_r;
    if (line_evt) begin
      if (req.overrun_seen) err_nxt[ERR_OVERRUN] = 1'b1;
      if (req.framing_error_seen) err_nxt[ERR_FRAMING] = 1'b1;
      if (rx_full) err_nxt[ERR_OVERFLOW] = 1'b1;
    end
    irq_nxt = irq_r;
    if (tx_push) irq_nxt = 1'b1;
    else if (tx_idle_evt) irq_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_wptr_r <= '0;
      rx_rptr_r <= '0;
      tx_wptr_r <= '0;
      tx_rptr_r <= '0;
      err_r     <= '0;
      irq_r     <= 1'b0;
      pend_rd_r <= 1'b0;
      pend_sd_r <= 1'b0;
      pend_wr_r <= 1'b0;
    end else begin
      rx_wptr_r <= rx_wptr_nxt;
      rx_rptr_r <= rx_rptr_nxt;
      tx_wptr_r <= tx_wptr_nxt;
      tx_rptr_r <= tx_rptr_nxt;
      err_r     <= err_nxt;
      irq_r     <= irq_nxt;
      if (cmd.exec) begin
        pend_rd_r <= rx_pop;
        pend_sd_r <= tx_pop;
        pend_wr_r <= tx_push;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rx_push) rx_mem[rx_wptr_r] <= req.line_byte;
    if (rx_pop) rx_rd_data_r <= rx_mem[rx_rptr_r];
  end

  always_ff @(posedge clk) begin
    if (tx_push) tx_mem[tx_wptr_r] <= req.host_byte;
    if (tx_pop) tx_rd_data_r <= tx_mem[tx_rptr_r];
  end

  // pointers already reflect the executed request here
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_r.read_valid     <= pend_rd_r;
      res_r.read_byte      <= pend_rd_r ? rx_rd_data_r : '0;
      res_r.send_valid     <= pend_sd_r;
      res_r.send_byte      <= pend_sd_r ? tx_rd_data_r : '0;
      res_r.write_accepted <= pend_wr_r;
      res_r.error_flags    <= err_r;
      res_r.rx_nonempty    <= !rx_empty;
      res_r.tx_empty       <= tx_empty;
      res_r.ready_irq_on   <= irq_r;
    end
  end

  assign res = res_r;

endmodule

[src/uart_rx_tx_ring_buffers_unit.sv]
// uart receive/transmit ring buffer unit, top level
// depends on urb_pkg, urb_ifs, urb_ctrl and urb_dp
//
// Each request transaction (line byte, host read, host write, transmitter
// ready) produces exactly one result transaction carrying the popped byte,
// the accept flag and the status after the update. In the accept cycle a
// request updates pointers and flags and starts the read of the ring
// memory; in the EXEC state, once the output register is free, the
// registered read data moves into the output register. A new request is
// taken once the previous result has entered the output register, as the
// ring memories have a registered read port.
// Each ring holds depth-1 bytes. No clearing pass runs after reset.
module uart_rx_tx_ring_buffers_unit
  import urb_pkg::*;
#(
  parameter int unsigned RX_DEPTH = RX_DEPTH_DEF,
  parameter int unsigned TX_DEPTH = TX_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  urb_in_if.sink    in_ch,
  urb_out_if.source out_ch
);

  urb_cmd_t cmd;
  urb_req_t req;
  urb_res_t res;

  assign req.req_type           = urb_req_e_t'(in_ch.req_type);
  assign req.line_byte          = in_ch.line_byte;
  assign req.overrun_seen       = in_ch.overrun_seen;
  assign req.framing_error_seen = in_ch.framing_error_seen;
  assign req.host_byte          = in_ch.host_byte;

  urb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  urb_dp #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH)
  ) u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .req   (req),
    .res   (res)
  );

  assign out_ch.read_valid     = res.read_valid;
  assign out_ch.read_byte      = res.read_byte;
  assign out_ch.send_valid     = res.send_valid;
  assign out_ch.send_byte      = res.send_byte;
  assign out_ch.write_accepted = res.write_accepted;
  assign out_ch.error_flags    = res.error_flags;
  assign out_ch.rx_nonempty    = res.rx_nonempty;
  assign out_ch.tx_empty       = res.tx_empty;
  assign out_ch.ready_irq_on   = res.ready_irq_on;

endmodule

[src/urb_checker.sv]
// port-level assertions for the uart ring buffer unit, bound to the top level
// depends on assert_macros.svh and uart_rx_tx_ring_buffers_unit
`include "assert_macros.svh"

module urb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       read_valid,
  input logic [7:0] read_byte,
  input logic       send_valid,
  input logic [7:0] send_byte,
  input logic       write_accepted,
  input logic [2:0] error_flags,
  input logic       tx_empty,
  input logic       ready_irq_on
);

  // stalled result holds
  `URB_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({read_valid, read_byte, send_valid, send_byte, write_accepted, error_flags, tx_empty, ready_irq_on}))

  // one request kind per result
  `URB_ASSERT_IMP(a_one_kind, out_valid, $onehot0({read_valid, send_valid, write_accepted}))

  // an accepted write leaves data queued and the interrupt enabled
  `URB_ASSERT_IMP(a_wr_irq, out_valid && write_accepted, ready_irq_on && !tx_empty)

  // unused byte fields read zero
  `URB_ASSERT_IMP(a_zero_bytes, out_valid, (read_valid || (read_byte == 8'd0)) && (send_valid || (send_byte == 8'd0)))

  // only one request in flight
  `URB_ASSERT_NXT(a_one_inflight, in_valid && in_ready, !in_ready)

endmodule

bind uart_rx_tx_ring_buffers_unit urb_checker u_urb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .read_valid     (out_ch.read_valid),
  .read_byte      (out_ch.read_byte),
  .send_valid     (out_ch.send_valid),
  .send_byte      (out_ch.send_byte),
  .write_accepted (out_ch.write_accepted),
  .error_flags    (out_ch.error_flags),
  .tx_empty       (out_ch.tx_empty),
  .ready_irq_on   (out_ch.ready_irq_on)
);
